[rtl/fca_pkg.sv]
// Shared widths, register indexes and divider constants for the frame averager.
package fca_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 32;
    localparam int SPF_W      = 17;
    localparam int CNT_W      = 16;
    localparam int SKIP_W     = 16;
    localparam int INDEX_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Sums stay below 2^31 in magnitude, so the quotient needs 31 steps.
    localparam int DIV_STEPS  = 31;
    localparam int DIV_CNT_W  = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLES_PER_FRAME = 2'd0,
        CFG_FRAME_COUNT       = 2'd1,
        CFG_SKIP_COUNT        = 2'd2
    } cfg_reg_t;

endpackage

[rtl/frame_coherent_averager.sv]
// Coherent frame averager: per-index sums over frames, averaged on the final frame.
// Flow: a dropped sample is only taken in; a summed sample is read from memory on its
// transfer, then added and written back in ST_ACC; on the final frame its sum then passes
// the 31-step serial divider and waits for a free output register before the average loads.
// Input is stalled outside ST_IDLE, so no new sample is taken until the last one is done.
// Reset: registers return to 65536 / 1 / 0, counters clear; sum memory is not cleared.
module frame_coherent_averager
    import fca_pkg::*;
#(
    parameter int FRAME_MAX = 65536
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [SAMPLE_W-1:0]  sample,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [SAMPLE_W-1:0]  average,
    output logic [INDEX_W-1:0]          sample_index,
    output logic                        last_of_frame
);

    // Frame index width, and a length width that holds both the register and FRAME_MAX.
    localparam int POS_W = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;
    localparam int LEN_W = ($clog2(FRAME_MAX + 1) > SPF_W) ? $clog2(FRAME_MAX + 1) : SPF_W;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(FRAME_MAX);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,   // waiting for a sample
        ST_ACC  = 3'b010,   // read data back, add, write the sum
        ST_DIV  = 3'b100    // final frame: divide and hand to the output register
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [SPF_W-1:0]  spf_reg;
    logic [CNT_W-1:0]  fcount_reg;
    logic [SKIP_W-1:0] skip_reg;

    // Run counters
    logic [POS_W-1:0]  position_reg;
    logic [CNT_W-1:0]  frames_done_reg;
    logic [SKIP_W-1:0] skip_left_reg;

    // Item held while it is summed
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [POS_W-1:0]           idx_reg;
    logic                       last_reg;

    // Output register
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] average_reg;
    logic [INDEX_W-1:0]         index_reg;
    logic                       last_out_reg;

    logic                       cfg_hit;
    logic                       in_xfer;
    logic                       take_skip;
    logic [LEN_W-1:0]           spf_ext;
    logic [LEN_W-1:0]           frame_len;
    logic [LEN_W-1:0]           idx_ext;
    logic                       idx_last;
    logic [CNT_W-1:0]           eff_count;
    logic [CNT_W:0]             fd_inc;
    logic                       final_frame;
    logic signed [SUM_W-1:0]    sample_ext;
    logic signed [SUM_W-1:0]    rd_data;
    logic signed [SUM_W-1:0]    acc_sum;
    logic                       acc_step;
    logic                       div_start;
    logic                       div_done;
    logic signed [SAMPLE_W-1:0] div_quotient;
    logic                       out_free;
    logic                       load_out;

    // Only the three listed indexes write, and each write restarts the run.
    always_comb
    begin
        unique case (cfg_reg_t'(cfg_index)) inside
            CFG_SAMPLES_PER_FRAME, CFG_FRAME_COUNT, CFG_SKIP_COUNT: cfg_hit = cfg_write;
            default:                                                 cfg_hit = 1'b0;
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign take_skip = in_xfer && (skip_left_reg != '0);

    // Effective frame length: zero acts as one, oversize saturates to FRAME_MAX.
    assign spf_ext   = LEN_W'(spf_reg);
    assign frame_len = (spf_ext == '0)     ? LEN_W'(1) :
                       (spf_ext > LEN_MAX) ? LEN_MAX   : spf_ext;
    assign idx_ext   = LEN_W'(idx_reg);
    assign idx_last  = (idx_ext == frame_len - LEN_W'(1));

    assign eff_count   = (fcount_reg == '0) ? CNT_W'(1) : fcount_reg;
    assign fd_inc      = {1'b0, frames_done_reg} + (CNT_W + 1)'(1);
    assign final_frame = (fd_inc >= {1'b0, eff_count});

    // First frame writes the sample; later frames add to the stored sum.
    assign sample_ext = {{(SUM_W - SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};
    assign acc_sum    = (frames_done_reg == '0) ? sample_ext : rd_data + sample_ext;

    assign acc_step  = (state_reg == ST_ACC);
    assign div_start = acc_step && final_frame;
    assign out_free  = !out_valid_reg || !out_stall;
    assign load_out  = (state_reg == ST_DIV) && div_done && out_free;

    // Read is issued on the transfer edge, so data is ready in ST_ACC.
    fca_sum_mem #(
        .DEPTH  (FRAME_MAX),
        .ADDR_W (POS_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (in_xfer),
        .rd_addr (position_reg),
        .rd_data (rd_data),
        .wr_en   (acc_step),
        .wr_addr (idx_reg),
        .wr_data (acc_sum)
    );

    fca_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_sum),
        .divisor  (eff_count),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (skip_left_reg == '0))
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                state_next = final_frame ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            spf_reg         <= SPF_W'(65536);
            fcount_reg      <= CNT_W'(1);
            skip_reg        <= '0;
            position_reg    <= '0;
            frames_done_reg <= '0;
            skip_left_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_hit)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_SAMPLES_PER_FRAME: spf_reg    <= cfg_data[SPF_W-1:0];
                    CFG_FRAME_COUNT:       fcount_reg <= cfg_data[CNT_W-1:0];
                    CFG_SKIP_COUNT:        skip_reg   <= cfg_data[SKIP_W-1:0];
                    default:               skip_reg   <= skip_reg;
                endcase
            end

            if (cfg_hit)
            begin
                position_reg    <= '0;
                frames_done_reg <= '0;
                skip_left_reg   <= (cfg_reg_t'(cfg_index) == CFG_SKIP_COUNT) ?
                                   cfg_data[SKIP_W-1:0] : skip_reg;
            end
            else if (take_skip)
            begin
                skip_left_reg <= skip_left_reg - SKIP_W'(1);
            end
            else if (acc_step)
            begin
                if (idx_last)
                begin
                    position_reg <= '0;
                    if (final_frame)
                    begin
                        // run complete: rearm
                        frames_done_reg <= '0;
                        skip_left_reg   <= skip_reg;
                    end
                    else
                    begin
                        frames_done_reg <= fd_inc[CNT_W-1:0];
                    end
                end
                else
                begin
                    position_reg <= idx_reg + POS_W'(1);
                end
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            sample_reg <= sample;
            idx_reg    <= position_reg;
        end
        if (acc_step)
        begin
            last_reg <= idx_last;
        end
        if (load_out)
        begin
            average_reg  <= div_quotient;
            index_reg    <= idx_ext[INDEX_W-1:0];
            last_out_reg <= last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign average       = average_reg;
    assign sample_index  = index_reg;
    assign last_of_frame = last_out_reg;

endmodule

[rtl/fca_sum_mem.sv]
// Accumulator memory: one write port, one registered read port.
module fca_sum_mem
    import fca_pkg::*;
#(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
)
(
    input  logic                    clk,
    input  logic                    rd_en,
    input  logic [ADDR_W-1:0]       rd_addr,
    output logic signed [SUM_W-1:0] rd_data,
    input  logic                    wr_en,
    input  logic [ADDR_W-1:0]       wr_addr,
    input  logic signed [SUM_W-1:0] wr_data
);

    logic signed [SUM_W-1:0] mem [DEPTH];
    logic signed [SUM_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/fca_div.sv]
// Bit-serial signed divider: 32-bit sum by 16-bit count, truncated toward zero.
module fca_div
    import fca_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [SUM_W-1:0]    dividend,
    input  logic [CNT_W-1:0]           divisor,
    output logic                       done,
    output logic signed [SAMPLE_W-1:0] quotient
);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] count_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [SUM_W-2:0]     quo_reg;
    logic [CNT_W-1:0]     divisor_reg;
    logic                 neg_reg;

    logic [SUM_W-1:0]     magnitude;
    logic [CNT_W:0]       shifted;
    logic [CNT_W:0]       trial;
    logic                 quo_bit;
    logic [SAMPLE_W-1:0]  quo_mag;

    assign magnitude = dividend[SUM_W-1] ? (SUM_W'(0) - dividend) : dividend;
    assign shifted   = {rem_reg, quo_reg[SUM_W-2]};
    assign trial     = shifted - {1'b0, divisor_reg};
    assign quo_bit   = ~trial[CNT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= '0;
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg + DIV_CNT_W'(1);
            if (count_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= magnitude[SUM_W-2:0];
            neg_reg     <= dividend[SUM_W-1];
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= quo_bit ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
            quo_reg <= {quo_reg[SUM_W-3:0], quo_bit};
        end
    end

    assign quo_mag  = quo_reg[SAMPLE_W-1:0];
    assign quotient = neg_reg ? (SAMPLE_W'(0) - quo_mag) : quo_mag;
    assign done     = ~busy_reg;

endmodule

[rtl/fca_checker.sv]
// Port-level checks for the frame averager, bound to the top level.
module fca_checker
    import fca_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic signed [SAMPLE_W-1:0] average,
    input logic [INDEX_W-1:0]         sample_index,
    input logic                       last_of_frame
);

    // A stalled result stays up.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(average) && $stable(sample_index)
                                   && $stable(last_of_frame))
        else $error("result payload changed while stalled");

    // A new result comes only out of the divide, while input is held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a divide in progress");

    // The divide spans the full serial run, with input held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall, DIV_STEPS - 1))
        else $error("result appeared sooner than the divider allows");

endmodule

bind frame_coherent_averager fca_checker u_fca_checker (.*);
